// ===== hdl/ecu_pkg.sv =====
// Shared types, constants and codes of the 8-bit CPU execute unit.
package ecu_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned FLAG_W    = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned REG_AW    = $clog2(NUM_REGS);
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned RIDX_W    = 3;
  localparam int unsigned MODE_W    = 5;
  localparam int unsigned COND_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Flag bit positions in the status word
  localparam int unsigned FLAG_V = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [DATA_W-1:0] STACK_START_RST   = 8'hFF;
  localparam logic [DATA_W-1:0] START_ADDRESS_RST = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_START   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    M_ST   = 5'd0,
    M_LD   = 5'd1,
    M_STS  = 5'd2,
    M_LDS  = 5'd3,
    M_CALL = 5'd4,
    M_RET  = 5'd5,
    M_BR   = 5'd6,
    M_JMP  = 5'd7,
    M_ADD  = 5'd8,
    M_SUB  = 5'd9,
    M_CP   = 5'd10,
    M_MOV  = 5'd11,
    M_CLC  = 5'd12,
    M_SEC  = 5'd13,
    M_ROR  = 5'd14,
    M_ROL  = 5'd15,
    M_STOP = 5'd16,
    M_ADDI = 5'd17,
    M_SUBI = 5'd18,
    M_CPI  = 5'd19,
    M_LDI  = 5'd20
  } mode_e;

  typedef enum logic [COND_W-1:0] {
    COND_EQ  = 2'd0,
    COND_LO  = 2'd1,
    COND_VS  = 2'd2,
    COND_LT  = 2'd3
  } cond_e;

  // One decoded instruction held in the execute stage
  typedef struct packed {
    mode_e             mode;
    logic [REG_AW-1:0] ra;
    logic [DATA_W-1:0] imm;
    cond_e             cond;
  } exec_op_t;

  // Architectural scalar state seen by the execute logic
  typedef struct packed {
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] sp;
    logic [FLAG_W-1:0] flags;
    logic              stopped;
  } arch_state_t;

  // Everything one instruction produces
  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic [DATA_W-1:0] sp;
    logic [FLAG_W-1:0] flags;
    logic [DATA_W-1:0] result;
    logic              mem_we;
    logic [DATA_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_data;
    logic              halted;
    logic              rf_we;
  } exec_res_t;

  // Register file write port
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

// ===== hdl/ecu_ifs.sv =====
// Valid/ready channel interfaces for instruction items and result items.
interface ecu_in_if;
  import ecu_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [RIDX_W-1:0]   reg_a;
  logic [RIDX_W-1:0]   reg_b;
  logic [DATA_W-1:0]   immediate;
  logic [COND_W-1:0]   condition;

  modport source (output valid, mode, reg_a, reg_b, immediate, condition, input ready);
  modport sink   (input valid, mode, reg_a, reg_b, immediate, condition, output ready);
endinterface

interface ecu_out_if;
  import ecu_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   next_pc;
  logic [FLAG_W-1:0]   flags;
  logic [DATA_W-1:0]   result_value;
  logic                mem_write;
  logic [DATA_W-1:0]   mem_address;
  logic [DATA_W-1:0]   mem_data;
  logic                halted;

  modport source (output valid, next_pc, flags, result_value, mem_write, mem_address,
                  mem_data, halted, input ready);
  modport sink   (input valid, next_pc, flags, result_value, mem_write, mem_address,
                  mem_data, halted, output ready);
endinterface

// ===== hdl/ecu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ecu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/ecu_regfile.sv =====
// Register file: two RAM copies for two read ports, reset valid bits, last-write bypass.
module ecu_regfile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [ecu_pkg::REG_AW-1:0]  ra_addr_i,
  input  logic [ecu_pkg::REG_AW-1:0]  rb_addr_i,
  input  ecu_pkg::rf_wr_t             wr_i,
  output logic [ecu_pkg::DATA_W-1:0]  a_data_o,
  output logic [ecu_pkg::DATA_W-1:0]  b_data_o
);
  import ecu_pkg::*;

  logic [DATA_W-1:0]   a_ram, b_ram;
  logic [NUM_REGS-1:0] vld_q, vld_d;
  logic [REG_AW-1:0]   ra_q, rb_q;
  rf_wr_t              last_q;
  logic                last_vld_q;

  ecu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (ra_addr_i),
    .rdata_o (a_ram)
  );

  ecu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (rb_addr_i),
    .rdata_o (b_ram)
  );

  // Valid bits: an entry never written reads as zero
  always_comb begin
    vld_d = vld_q;
    if (wr_i.we) begin
      vld_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      last_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (wr_i.we) begin
        last_vld_q <= 1'b1;
      end
    end
  end

  // Read addresses and the newest write (covers a write at the read edge)
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      ra_q <= ra_addr_i;
      rb_q <= rb_addr_i;
    end
    if (wr_i.we) begin
      last_q <= wr_i;
    end
  end

  always_comb begin
    if (last_vld_q && last_q.addr == ra_q) begin
      a_data_o = last_q.data;
    end else if (vld_q[ra_q]) begin
      a_data_o = a_ram;
    end else begin
      a_data_o = '0;
    end
    if (last_vld_q && last_q.addr == rb_q) begin
      b_data_o = last_q.data;
    end else if (vld_q[rb_q]) begin
      b_data_o = b_ram;
    end else begin
      b_data_o = '0;
    end
  end
endmodule

// ===== hdl/ecu_dmem.sv =====
// Data memory: one RAM with per-entry valid bits so unwritten bytes read as zero.
module ecu_dmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [ecu_pkg::MEM_AW-1:0]  raddr_i,
  input  logic                        we_i,
  input  logic [ecu_pkg::MEM_AW-1:0]  waddr_i,
  input  logic [ecu_pkg::DATA_W-1:0]  wdata_i,
  output logic [ecu_pkg::DATA_W-1:0]  rdata_o
);
  import ecu_pkg::*;

  logic [DATA_W-1:0]    ram_rdata;
  logic [MEM_DEPTH-1:0] vld_q;
  logic                 rd_vld_q;

  ecu_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Valid bits, sampled alongside the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? ram_rdata : '0;
endmodule

// ===== hdl/ecu_alu.sv =====
// Execute logic: decodes one instruction and computes its result and new state.
module ecu_alu (
  input  ecu_pkg::exec_op_t           op_i,
  input  ecu_pkg::arch_state_t        st_i,
  input  logic [ecu_pkg::DATA_W-1:0]  a_val_i,
  input  logic [ecu_pkg::DATA_W-1:0]  b_val_i,
  input  logic [ecu_pkg::DATA_W-1:0]  mem_rdata_i,
  output ecu_pkg::exec_res_t          res_o
);
  import ecu_pkg::*;

  logic [DATA_W-1:0] opb, opb_neg, sum, pc_inc, rot;
  logic              is_sub, take;
  logic [FLAG_W-1:0] ar_flags, rot_flags;

  // Shared adder for add, sub, compare and their immediate forms
  always_comb begin
    is_sub  = (op_i.mode == M_SUB) || (op_i.mode == M_CP) ||
              (op_i.mode == M_SUBI) || (op_i.mode == M_CPI);
    opb     = (op_i.mode == M_ADDI || op_i.mode == M_SUBI || op_i.mode == M_CPI) ?
              op_i.imm : b_val_i;
    opb_neg = is_sub ? (~opb + 8'd1) : opb;
    sum     = a_val_i + opb_neg;
    ar_flags[FLAG_V] = (a_val_i[DATA_W-1] == opb_neg[DATA_W-1]) &&
                       (a_val_i[DATA_W-1] != sum[DATA_W-1]);
    ar_flags[FLAG_N] = sum[DATA_W-1];
    ar_flags[FLAG_Z] = (sum == '0);
    ar_flags[FLAG_C] = is_sub ? (sum >= a_val_i) : (sum < a_val_i);
  end

  // Rotates through carry
  always_comb begin
    if (op_i.mode == M_ROR) begin
      rot = {st_i.flags[FLAG_C], a_val_i[DATA_W-1:1]};
      rot_flags[FLAG_V] = a_val_i[DATA_W-1] ^ st_i.flags[FLAG_C];
      rot_flags[FLAG_N] = st_i.flags[FLAG_C];
      rot_flags[FLAG_C] = a_val_i[0];
    end else begin
      rot = {a_val_i[DATA_W-2:0], st_i.flags[FLAG_C]};
      rot_flags[FLAG_V] = a_val_i[DATA_W-1] ^ a_val_i[DATA_W-2];
      rot_flags[FLAG_N] = a_val_i[DATA_W-2];
      rot_flags[FLAG_C] = a_val_i[DATA_W-1];
    end
    rot_flags[FLAG_Z] = (rot == '0);
  end

  // Branch condition
  always_comb begin
    unique case (op_i.cond)
      COND_EQ: take = st_i.flags[FLAG_Z];
      COND_LO: take = st_i.flags[FLAG_C];
      COND_VS: take = st_i.flags[FLAG_V];
      COND_LT: take = st_i.flags[FLAG_V] ^ st_i.flags[FLAG_N];
      default: take = 1'b0;
    endcase
  end

  assign pc_inc = st_i.pc + 8'd1;

  // Instruction decode
  always_comb begin
    res_o          = '0;
    res_o.next_pc  = pc_inc;
    res_o.sp       = st_i.sp;
    res_o.flags    = st_i.flags;
    res_o.halted   = st_i.stopped;
    if (st_i.stopped) begin
      res_o.next_pc = st_i.pc;
    end else begin
      unique case (op_i.mode)
        M_ST, M_STS: begin
          res_o.mem_addr = (op_i.mode == M_ST) ? b_val_i : op_i.imm;
          res_o.mem_data = a_val_i;
          res_o.mem_we   = 1'b1;
          res_o.result   = a_val_i;
        end
        M_LD, M_LDS: begin
          res_o.mem_addr = (op_i.mode == M_LD) ? b_val_i : op_i.imm;
          res_o.mem_data = mem_rdata_i;
          res_o.result   = mem_rdata_i;
          res_o.rf_we    = 1'b1;
        end
        M_CALL: begin
          res_o.mem_addr = st_i.sp;
          res_o.mem_data = pc_inc;
          res_o.mem_we   = 1'b1;
          res_o.sp       = st_i.sp - 8'd1;
          res_o.result   = op_i.imm;
          res_o.next_pc  = op_i.imm;
        end
        M_RET: begin
          res_o.sp       = st_i.sp + 8'd1;
          res_o.mem_addr = st_i.sp + 8'd1;
          res_o.mem_data = mem_rdata_i;
          res_o.result   = mem_rdata_i;
          res_o.next_pc  = mem_rdata_i;
        end
        M_BR: begin
          if (take) begin
            res_o.next_pc = op_i.imm;
            res_o.result  = op_i.imm;
          end
        end
        M_JMP: begin
          res_o.next_pc = op_i.imm;
          res_o.result  = op_i.imm;
        end
        M_ADD, M_SUB, M_ADDI, M_SUBI: begin
          res_o.result = sum;
          res_o.flags  = ar_flags;
          res_o.rf_we  = 1'b1;
        end
        M_CP, M_CPI: begin
          res_o.result = sum;
          res_o.flags  = ar_flags;
        end
        M_MOV: begin
          res_o.result = b_val_i;
          res_o.rf_we  = 1'b1;
        end
        M_CLC: res_o.flags[FLAG_C] = 1'b0;
        M_SEC: res_o.flags[FLAG_C] = 1'b1;
        M_ROR, M_ROL: begin
          res_o.result = rot;
          res_o.flags  = rot_flags;
          res_o.rf_we  = 1'b1;
        end
        M_STOP: res_o.halted = 1'b1;
        M_LDI: begin
          res_o.result = op_i.imm;
          res_o.rf_we  = 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/eight_bit_cpu_execute_unit.sv =====
// Top level of the 8-bit CPU execute unit.
// Path: an instruction is registered into the execute stage, then its result into
//   the output register; ld, lds and ret read the data memory and hold the stage.
// Throughput: one instruction per cycle, but for ld, lds and ret and result stalls.
// Reset: registers, flags and stop state cleared, pc and sp from their reset values;
//   register file and data memory read zero through valid bits, no clearing pass.
module eight_bit_cpu_execute_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ecu_in_if.sink                         in_i,
  ecu_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ecu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ecu_pkg::DATA_W-1:0]     cfg_data_i
);
  import ecu_pkg::*;

  exec_op_t          ex_op_q;
  logic              ex_valid_q, ex_valid_d;
  logic              ld_phase_q, ld_phase_d;
  arch_state_t       st_q;
  exec_res_t         res, out_q;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer, out_free, is_load, ex_done, dmem_re;
  logic [DATA_W-1:0] a_val, b_val, dmem_rdata;
  rf_wr_t            rf_wr;

  // Handshake and execute-stage control
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign is_load  = !st_q.stopped &&
                    (ex_op_q.mode == M_LD || ex_op_q.mode == M_LDS || ex_op_q.mode == M_RET);
  assign ex_done  = ex_valid_q && (!is_load || ld_phase_q) && out_free;
  assign dmem_re  = ex_valid_q && is_load && !ld_phase_q;
  assign in_i.ready = !ex_valid_q || ex_done;

  always_comb begin
    ex_valid_d = ex_valid_q;
    ld_phase_d = ld_phase_q;
    if (ex_done) begin
      ex_valid_d = 1'b0;
      ld_phase_d = 1'b0;
    end else if (dmem_re) begin
      ld_phase_d = 1'b1;
    end
    if (in_xfer) begin
      ex_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (ex_done) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      ld_phase_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      ld_phase_q  <= ld_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Instruction and result registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ex_op_q.mode <= mode_e'(in_i.mode);
      ex_op_q.ra   <= REG_AW'(in_i.reg_a);
      ex_op_q.imm  <= in_i.immediate;
      ex_op_q.cond <= cond_e'(in_i.condition);
    end
    if (ex_done) begin
      out_q <= res;
    end
  end

  // Architectural scalar state: updated on completion, loaded by configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pc      <= START_ADDRESS_RST;
      st_q.sp      <= STACK_START_RST;
      st_q.flags   <= '0;
      st_q.stopped <= 1'b0;
    end else begin
      if (ex_done) begin
        st_q.pc      <= res.next_pc;
        st_q.sp      <= res.sp;
        st_q.flags   <= res.flags;
        st_q.stopped <= res.halted;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STACK_START:   st_q.sp <= cfg_data_i;
          CFG_START_ADDRESS: st_q.pc <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Register file: read on transfer in, written on completion
  assign rf_wr.we   = ex_done && res.rf_we;
  assign rf_wr.addr = ex_op_q.ra;
  assign rf_wr.data = res.result;

  ecu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_xfer),
    .ra_addr_i (REG_AW'(in_i.reg_a)),
    .rb_addr_i (REG_AW'(in_i.reg_b)),
    .wr_i      (rf_wr),
    .a_data_o  (a_val),
    .b_data_o  (b_val)
  );

  // Data memory: loads read in their first execute cycle, stores write on completion
  ecu_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (dmem_re),
    .raddr_i (MEM_AW'(res.mem_addr)),
    .we_i    (ex_done && res.mem_we),
    .waddr_i (MEM_AW'(res.mem_addr)),
    .wdata_i (res.mem_data),
    .rdata_o (dmem_rdata)
  );

  ecu_alu u_alu (
    .op_i        (ex_op_q),
    .st_i        (st_q),
    .a_val_i     (a_val),
    .b_val_i     (b_val),
    .mem_rdata_i (dmem_rdata),
    .res_o       (res)
  );

  // Result channel
  assign out_o.valid        = out_valid_q;
  assign out_o.next_pc      = out_q.next_pc;
  assign out_o.flags        = out_q.flags;
  assign out_o.result_value = out_q.result;
  assign out_o.mem_write    = out_q.mem_we;
  assign out_o.mem_address  = out_q.mem_addr;
  assign out_o.mem_data     = out_q.mem_data;
  assign out_o.halted       = out_q.halted;
endmodule

// ===== hdl/ecu_checker.sv =====
// Port-level checks on the execute unit, bound to the top level.
module ecu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ecu_pkg::DATA_W-1:0]  out_next_pc_i,
  input logic [ecu_pkg::DATA_W-1:0]  out_result_i,
  input logic                        out_mem_write_i,
  input logic [ecu_pkg::DATA_W-1:0]  out_mem_address_i,
  input logic                        out_halted_i
);
  import ecu_pkg::*;

  logic [1:0] pend_q;
  logic       halted_seen_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Items taken in but not yet delivered, and whether stop was reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= '0;
      halted_seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
      if (out_xfer && out_halted_i) begin
        halted_seen_q <= 1'b1;
      end
    end
  end

  // A result needs an instruction behind it
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result offered without a pending instruction");

  // Once stopped, the machine stays stopped
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halted_seen_q |-> out_halted_i)
    else $error("halted dropped after stop");

  // A halted result moves no data
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_halted_i |->
      !out_mem_write_i && out_result_i == '0 && out_mem_address_i == '0)
    else $error("halted result carries data");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_next_pc_i) && $stable(out_result_i))
    else $error("stalled result changed");
endmodule

bind eight_bit_cpu_execute_unit ecu_checker u_ecu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_next_pc_i     (out_o.next_pc),
  .out_result_i      (out_o.result_value),
  .out_mem_write_i   (out_o.mem_write),
  .out_mem_address_i (out_o.mem_address),
  .out_halted_i      (out_o.halted)
);
